>>> sv/u8d_pkg.sv
// Shared types and constants for the UTF-8 codepoint decoder.
// No dependencies; used by every module under sv/.

package u8d_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [20:0] QMARK_CP = 21'h00003f;

    // Input beat: one byte of text
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_beat_t;

    // Output beat: one decoded codepoint
    typedef struct packed {
        logic [20:0] codepoint;
        logic [2:0]  bytes_used;
        logic        invalid;
        logic        last;
    } out_beat_t;

    // Work for the back end caused by one input byte:
    // pre_q '?' beats, then an optional middle beat, then post_q '?' beats.
    typedef struct packed {
        logic [1:0]  pre_q;
        logic        mid_valid;
        logic        mid_invalid;
        logic [20:0] mid_cp;
        logic [2:0]  mid_used;
        logic [1:0]  post_q;
    } job_t;

    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } lead_class_t;

endpackage

>>> sv/u8d_front.sv
// Front end of the UTF-8 decoder: takes bytes, tracks the sequence in progress
// and turns each byte into a job for the back end. Depends on u8d_pkg.

module u8d_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  u8d_pkg::in_beat_t  byte_data,
    input  logic               q_full,
    output logic               q_push,
    output u8d_pkg::job_t      q_job
);

    logic [7:0] held_reg [3];
    logic [1:0] held_cnt_reg;
    logic [1:0] held_cnt_next;
    logic [1:0] need_cnt_reg;
    logic [1:0] need_cnt_next;

    logic        accept;
    logic        active;
    logic        second_ok;
    logic        cont_ok;
    logic        lead_path;
    logic        held_wr_en;
    logic [1:0]  held_wr_idx;
    logic [7:0]  b;
    logic [5:0]  t;
    logic [20:0] cp_full;
    u8d_pkg::lead_class_t lead_class;
    u8d_pkg::job_t        job;

    assign b          = byte_data.text_byte;
    assign t          = b[5:0];
    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;
    assign active     = (held_cnt_reg != 2'd0) && (need_cnt_reg != 2'd0);

    // Lead byte decoder
    always_comb
    begin
        unique case (b) inside
            [8'h00:8'h7f]: lead_class = u8d_pkg::LEAD_ASCII;
            [8'hc2:8'hdf]: lead_class = u8d_pkg::LEAD_TWO;
            [8'he0:8'hef]: lead_class = u8d_pkg::LEAD_THREE;
            [8'hf0:8'hf4]: lead_class = u8d_pkg::LEAD_FOUR;
            default:       lead_class = u8d_pkg::LEAD_BAD;
        endcase
    end

    // Second-byte range limits for E0, ED, F0, F4 (overlongs, surrogates, > 10FFFF)
    always_comb
    begin
        second_ok = 1'b1;
        if (held_cnt_reg == 2'd1)
        begin
            unique case (held_reg[0])
                8'he0:   second_ok = (b >= 8'ha0);
                8'hed:   second_ok = (b <= 8'h9f);
                8'hf0:   second_ok = (b >= 8'h90);
                8'hf4:   second_ok = (b <= 8'h8f);
                default: second_ok = 1'b1;
            endcase
        end
    end

    assign cont_ok = (b[7:6] == 2'b10) && second_ok;

    always_comb
    begin
        unique case (held_cnt_reg)
            2'd1:    cp_full = {10'd0, held_reg[0][4:0], t};
            2'd2:    cp_full = {5'd0, held_reg[0][3:0], held_reg[1][5:0], t};
            2'd3:    cp_full = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0], t};
            default: cp_full = {15'd0, t};
        endcase
    end

    always_comb
    begin
        job           = '0;
        held_cnt_next = held_cnt_reg;
        need_cnt_next = need_cnt_reg;
        held_wr_en    = 1'b0;
        held_wr_idx   = held_cnt_reg;
        lead_path     = 1'b0;

        if (!active)
        begin
            lead_path = 1'b1;
        end
        else if (!cont_ok)
        begin
            // broken sequence: one '?' per held byte, then re-decode this byte
            job.pre_q = held_cnt_reg;
            lead_path = 1'b1;
        end
        else if (need_cnt_reg == 2'd1)
        begin
            job.mid_valid = 1'b1;
            job.mid_cp    = cp_full;
            job.mid_used  = {1'b0, held_cnt_reg} + 3'd1;
            held_cnt_next = 2'd0;
            need_cnt_next = 2'd0;
        end
        else
        begin
            held_wr_en    = 1'b1;
            held_cnt_next = held_cnt_reg + 2'd1;
            need_cnt_next = need_cnt_reg - 2'd1;
        end

        if (lead_path)
        begin
            held_cnt_next = 2'd0;
            need_cnt_next = 2'd0;
            case (lead_class) inside
                u8d_pkg::LEAD_ASCII:
                begin
                    job.mid_valid = 1'b1;
                    job.mid_cp    = {13'd0, b};
                    job.mid_used  = 3'd1;
                end
                u8d_pkg::LEAD_TWO, u8d_pkg::LEAD_THREE, u8d_pkg::LEAD_FOUR:
                begin
                    held_wr_en    = 1'b1;
                    held_wr_idx   = 2'd0;
                    held_cnt_next = 2'd1;
                    if (lead_class == u8d_pkg::LEAD_TWO)
                        need_cnt_next = 2'd1;
                    else if (lead_class == u8d_pkg::LEAD_THREE)
                        need_cnt_next = 2'd2;
                    else
                        need_cnt_next = 2'd3;
                end
                default:
                begin
                    job.mid_valid   = 1'b1;
                    job.mid_invalid = 1'b1;
                    job.mid_cp      = u8d_pkg::QMARK_CP;
                    job.mid_used    = 3'd1;
                end
            endcase
        end

        // end of text: unfinished bytes each give '?'
        if (byte_data.end_of_text && (held_cnt_next != 2'd0))
        begin
            job.post_q    = held_cnt_next;
            held_cnt_next = 2'd0;
            need_cnt_next = 2'd0;
        end
    end

    assign q_job  = job;
    assign q_push = accept &&
                    ((job.pre_q != 2'd0) || job.mid_valid || (job.post_q != 2'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= 2'd0;
            need_cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            held_cnt_reg <= held_cnt_next;
            need_cnt_reg <= need_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && held_wr_en)
            held_reg[held_wr_idx] <= b;
    end

    // held and needed counts are either both zero or both set
    a_counts_paired: assert property (@(posedge clk) disable iff (!rst_n)
        (held_cnt_reg == 2'd0) == (need_cnt_reg == 2'd0))
        else $error("held and needed counts out of step");

    // a sequence in progress spans two to four bytes
    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        (held_cnt_reg != 2'd0) |->
            (({1'b0, held_cnt_reg} + {1'b0, need_cnt_reg}) >= 3'd2) &&
            (({1'b0, held_cnt_reg} + {1'b0, need_cnt_reg}) <= 3'd4))
        else $error("sequence length out of range");

    // end of text leaves nothing held
    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_data.end_of_text) |=> (held_cnt_reg == 2'd0))
        else $error("state not cleared at end of text");

endmodule

>>> sv/u8d_fifo.sv
// Short job queue between the decoder front and back ends.
// Depends on u8d_pkg for the job type.

module u8d_fifo
#(
    parameter int unsigned DEPTH = u8d_pkg::FIFO_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  u8d_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output u8d_pkg::job_t head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    u8d_pkg::job_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> sv/u8d_back.sv
// Back end of the UTF-8 decoder: expands the queue head into output beats
// and holds them in the output register. Depends on u8d_pkg.

module u8d_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  u8d_pkg::job_t      head_job,
    output logic               pop,
    output logic               cp_valid,
    input  logic               cp_ready,
    output u8d_pkg::out_beat_t cp_data
);

    logic [1:0]         beat_idx_reg;
    logic [1:0]         beat_idx_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    u8d_pkg::out_beat_t out_data_reg;
    u8d_pkg::out_beat_t beat;
    logic [2:0]         job_total;
    logic               load;
    logic               is_mid;
    logic               is_last;

    assign job_total = {1'b0, head_job.pre_q} + {2'b00, head_job.mid_valid}
                     + {1'b0, head_job.post_q};
    assign is_mid    = head_job.mid_valid && (beat_idx_reg == head_job.pre_q);
    assign is_last   = (({1'b0, beat_idx_reg} + 3'd1) == job_total);
    assign load      = !out_valid_reg || cp_ready;
    assign pop       = load && head_valid && is_last;

    always_comb
    begin
        if (is_mid)
        begin
            beat.codepoint  = head_job.mid_cp;
            beat.bytes_used = head_job.mid_used;
            beat.invalid    = head_job.mid_invalid;
        end
        else
        begin
            beat.codepoint  = u8d_pkg::QMARK_CP;
            beat.bytes_used = 3'd1;
            beat.invalid    = 1'b1;
        end
        beat.last = is_last;
    end

    always_comb
    begin
        beat_idx_next  = beat_idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
                beat_idx_next = is_last ? 2'd0 : beat_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_idx_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            beat_idx_reg  <= beat_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
            out_data_reg <= beat;
    end

    assign cp_valid = out_valid_reg;
    assign cp_data  = out_data_reg;

    // the beat index never runs past the job at the head
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, beat_idx_reg} < job_total))
        else $error("beat index beyond job");

    // with the queue empty no job is part-way through
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (beat_idx_reg == 2'd0))
        else $error("beat index not reset between jobs");

    // a substituted beat is always a single-byte '?'
    a_qmark_form: assert property (@(posedge clk) disable iff (!rst_n)
        (cp_valid && cp_data.invalid) |->
            ((cp_data.codepoint == u8d_pkg::QMARK_CP) && (cp_data.bytes_used == 3'd1)))
        else $error("malformed substitution beat");

endmodule

>>> sv/utf8_codepoint_decoder_top.sv
// Top level of the streaming UTF-8 (RFC 3629) codepoint decoder.
// Instantiates u8d_front, u8d_fifo and u8d_back; depends on u8d_pkg.
//
// Usage:
//   byte channel (byte_valid/byte_ready/byte_data) takes one text byte per beat,
//   with end_of_text marking the final byte of a text.
//   cp channel (cp_valid/cp_ready/cp_data) gives decoded codepoints, one per beat;
//   last marks the final beat caused by a given input byte. A byte may cause no
//   beat (lead or middle continuation byte) or up to four (broken sequence
//   flushed as '?' beats, then the re-decoded byte, then end-of-text flushes).
// Throughput: one byte per cycle while the job queue is not full; the back end
//   issues the output beats caused by a byte one after another.
// Path: a taken byte's job is written to the queue, then moved from the queue
//   head into the output register, which drives cp_valid and cp_data.
// The job queue (QUEUE_DEPTH entries) absorbs error bursts; byte_ready drops
//   only while it is full.
// Stall: with cp_ready low the output register holds its beat, the back end
//   stops, and the queue fills before the input stalls.
// Reset: rst_n clears the sequence state, the queue and cp_valid, not cp_data.
//   No sequence is in progress afterwards; no clearing pass is needed.

module utf8_codepoint_decoder_top
#(
    parameter int unsigned QUEUE_DEPTH = u8d_pkg::FIFO_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  u8d_pkg::in_beat_t  byte_data,
    output logic               cp_valid,
    input  logic               cp_ready,
    output u8d_pkg::out_beat_t cp_data
);

    logic          q_full;
    logic          q_push;
    u8d_pkg::job_t q_push_job;
    logic          q_pop;
    logic          q_head_valid;
    u8d_pkg::job_t q_head_job;

    // sequence tracking and classification
    u8d_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (q_push_job)
    );

    // decouples the byte side from output stalls
    u8d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // beat expansion and output register
    u8d_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .cp_data    (cp_data)
    );

endmodule
